// File: rtl/core/wavp_pkg.sv
// Shared types and constants for the WAV 16-bit PCM header parser.
// Used by wavp_out_reg, the parser and the testbench; needs nothing else.
`timescale 1ns / 1ps

package wavp_pkg;

  // Output stream word width: 82 payload bits rounded up to whole bytes.
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_PAD_W   = 6;

  // Chunk tags as they appear in a little-endian 32-bit accumulator.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;  // "RIFF"
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;  // "WAVE"
  localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;  // "JUNK"
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;  // "fmt "
  localparam logic [31:0] TAG_DA   = 32'h0000_6164;  // "da"
  localparam logic [31:0] TAG_TA   = 32'h0000_6174;  // "ta"
  localparam logic [31:0] FMT_PCM  = 32'h0000_0001;

  typedef enum logic [4:0] {
    PH_RIFF   = 5'd0,
    PH_SIZE   = 5'd1,
    PH_WAVE   = 5'd2,
    PH_TAG    = 5'd3,
    PH_JLEN   = 5'd4,
    PH_SKIP   = 5'd5,
    PH_FMT2   = 5'd6,
    PH_CKSZ   = 5'd7,
    PH_TYPE   = 5'd8,
    PH_CHAN   = 5'd9,
    PH_RATE   = 5'd10,
    PH_BRATE  = 5'd11,
    PH_ALIGN  = 5'd12,
    PH_BITS   = 5'd13,
    PH_SCAN   = 5'd14,
    PH_TA     = 5'd15,
    PH_DSIZE  = 5'd16,
    PH_SAMPLE = 5'd17,
    PH_DONE   = 5'd18
  } wavp_phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } wavp_kind_e;

  typedef enum logic [2:0] {
    ERR_NOT_RIFF  = 3'd0,
    ERR_SIZE      = 3'd1,
    ERR_NOT_WAVE  = 3'd2,
    ERR_NO_FMT    = 3'd3,
    ERR_NO_FMT2   = 3'd4,
    ERR_NOT_PCM   = 3'd5,
    ERR_NO_TA     = 3'd6,
    ERR_TRUNCATED = 3'd7
  } wavp_err_e;

  // One result word, as handed from the parser to the output register.
  typedef struct packed {
    logic               last;
    wavp_kind_e         kind;
    wavp_err_e          code;
    logic        [30:0] count;
    logic        [31:0] rate;
    logic signed [15:0] sample;
  } wavp_result_t;

  // Index of the final byte of the field read in a given phase.
  function automatic logic [1:0] field_last(input wavp_phase_e ph);
    logic [1:0] idx;
    idx = 2'd3;
    unique case (ph)
      PH_TYPE, PH_CHAN, PH_ALIGN, PH_BITS,
      PH_SCAN, PH_TA, PH_SAMPLE:           idx = 2'd1;
      PH_SKIP, PH_DONE:                    idx = 2'd0;
      default:                             idx = 2'd3;
    endcase
    return idx;
  endfunction

endpackage

// File: rtl/core/wavp_out_reg.sv
// Result register for the WAV parser: holds one word toward the master side.
// Depends on wavp_pkg for the result struct and stream width.
`timescale 1ns / 1ps

module wavp_out_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  wavp_pkg::wavp_result_t              res_i,
  output logic                                ready_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: sample[15:0], rate[47:16], sample_count[78:48],
  // error_code[81:79], zero fill[87:82]
  output logic [wavp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]                          m_axis_tuser,
  // tlast: last_sample
  output logic                                m_axis_tlast
);
  import wavp_pkg::*;

  logic         vld_q, vld_d;
  wavp_result_t res_q;

  // A new word may enter when the register is empty or drains this cycle.
  assign ready_o = !vld_q || m_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (push_i) begin
      vld_d = 1'b1;
    end else if (m_axis_tready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_q.code, res_q.count, res_q.rate,
                          res_q.sample};
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tlast  = res_q.last;

endmodule

// File: rtl/core/wav_header_pcm16_parser.sv
// Top level of the WAV 16-bit PCM parser: header walk, sample assembly, config.
// Depends on wavp_pkg and instantiates wavp_out_reg.
`timescale 1ns / 1ps

// Channel   Direction  Payload                                   Handshake
// s_axis    in         tdata[7:0] file byte, tlast end of file   tvalid/tready
// m_axis    out        tdata sample/rate/count/code, tuser kind, tvalid/tready
//                      tlast last sample
// cfg       in         cfg_data_i file size in bytes             cfg_valid_i/cfg_ready_o
//
// One byte word is taken per cycle. Each accepted byte updates the parse state
// in the same cycle and produces at most one result word, which is registered
// in a single output register. The input is stalled only while that
// register holds a word that the master side does not take. Reset clears all
// parse state and sets the file size to zero. The configuration channel is
// always ready; the file size is meant to be written while the parser is idle.

module wav_header_pcm16_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel: the total file size in bytes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [31:0]                      cfg_data_i,
  // Input stream. tdata: data_byte[7:0]. tlast: end_of_file.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,
  input  logic                             s_axis_tlast,
  // Output stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: sample[15:0], rate[47:16], sample_count[78:48],
  // error_code[81:79], zero fill[87:82]
  output logic [wavp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: kind[1:0] (0 sample, 1 header, 2 error)
  output logic [1:0]                       m_axis_tuser,
  // tlast: last_sample
  output logic                             m_axis_tlast
);
  import wavp_pkg::*;

  // Configuration. The size check value and the small-file flag are formed
  // once at write time so the byte path only sees an equality compare.
  logic [31:0] file_size_q;
  logic [31:0] fs_m8_q;
  logic        fs_small_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      fs_m8_q     <= '0;
      fs_small_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      file_size_q <= cfg_data_i;
      fs_m8_q     <= cfg_data_i - 32'd8;
      fs_small_q  <= (cfg_data_i < 32'd8);
    end
  end

  // Parse state. A failed check moves straight to PH_DONE, where bytes are
  // dropped until end of file, exactly as after the final sample.
  wavp_phase_e phase_q, phase_d, phase_adv;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [31:0] field_q, field_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] rate_q, rate_d;
  logic [30:0] left_q, left_d;
  logic [7:0]  low_q, low_d;

  logic         accept;
  logic         out_ready;
  logic         have;
  wavp_result_t res;

  assign s_axis_tready = out_ready;
  assign accept        = s_axis_tvalid && out_ready;

  // Shared byte-path terms.
  logic [31:0] pos_inc;
  logic [31:0] fld_val;
  logic        fld_done;
  logic [30:0] left_dec;
  logic [30:0] dsz_half;
  logic [31:0] fs_rem;
  logic [30:0] cnt_fb;
  logic [30:0] cnt_new;
  logic        size_ok;

  assign pos_inc  = (pos_q == '1) ? pos_q : pos_q + 32'd1;
  assign fld_val  = field_q | ({24'd0, s_axis_tdata} << {byte_cnt_q, 3'b000});
  assign fld_done = (byte_cnt_q == field_last(phase_q));
  assign left_dec = left_q - 31'd1;
  assign dsz_half = fld_val[31:1];
  // Zero data size falls back to the bytes that remain after this one.
  assign fs_rem   = file_size_q - pos_inc;
  assign cnt_fb   = (file_size_q > pos_inc) ? fs_rem[31:1] : '0;
  assign cnt_new  = (dsz_half == '0) ? cnt_fb : dsz_half;
  assign size_ok  = !fs_small_q && (fld_val == fs_m8_q);

  // Next phase before the end-of-file restart is applied.
  always_comb begin
    phase_adv = phase_q;
    unique case (phase_q)
      PH_SKIP: begin
        if (skip_q == 32'd1) begin
          phase_adv = PH_FMT2;
        end
      end
      PH_SAMPLE: begin
        if (byte_cnt_q[0] && left_dec == '0) begin
          phase_adv = PH_DONE;
        end
      end
      PH_DONE: phase_adv = PH_DONE;
      default: begin
        if (fld_done) begin
          unique case (phase_q)
            PH_RIFF:  phase_adv = (fld_val == TAG_RIFF) ? PH_SIZE : PH_DONE;
            PH_SIZE:  phase_adv = size_ok ? PH_WAVE : PH_DONE;
            PH_WAVE:  phase_adv = (fld_val == TAG_WAVE) ? PH_TAG : PH_DONE;
            PH_TAG: begin
              if (fld_val == TAG_JUNK) begin
                phase_adv = PH_JLEN;
              end else if (fld_val == TAG_FMT) begin
                phase_adv = PH_CKSZ;
              end else begin
                phase_adv = PH_DONE;
              end
            end
            PH_JLEN:  phase_adv = (fld_val == '0) ? PH_FMT2 : PH_SKIP;
            PH_FMT2:  phase_adv = (fld_val == TAG_FMT) ? PH_CKSZ : PH_DONE;
            PH_CKSZ:  phase_adv = PH_TYPE;
            PH_TYPE:  phase_adv = (fld_val == FMT_PCM) ? PH_CHAN : PH_DONE;
            PH_CHAN:  phase_adv = PH_RATE;
            PH_RATE:  phase_adv = PH_BRATE;
            PH_BRATE: phase_adv = PH_ALIGN;
            PH_ALIGN: phase_adv = PH_BITS;
            PH_BITS:  phase_adv = PH_SCAN;
            PH_SCAN:  phase_adv = (fld_val == TAG_DA) ? PH_TA : PH_SCAN;
            PH_TA:    phase_adv = (fld_val == TAG_TA) ? PH_DSIZE : PH_DONE;
            PH_DSIZE: phase_adv = (cnt_new == '0) ? PH_DONE : PH_SAMPLE;
            default:  phase_adv = PH_DONE;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = s_axis_tlast ? PH_RIFF : phase_adv;
    end
  end

  // Datapath registers and the result word.
  always_comb begin
    byte_cnt_d = byte_cnt_q;
    field_d    = field_q;
    skip_d     = skip_q;
    pos_d      = pos_q;
    rate_d     = rate_q;
    left_d     = left_q;
    low_d      = low_q;
    have       = 1'b0;
    res        = '0;
    res.kind   = KIND_ERROR;

    if (accept) begin
      pos_d = pos_inc;
      unique case (phase_q)
        PH_SKIP: begin
          skip_d = skip_q - 32'd1;
        end
        PH_SAMPLE: begin
          if (!byte_cnt_q[0]) begin
            low_d      = s_axis_tdata;
            byte_cnt_d = 2'd1;
          end else begin
            byte_cnt_d = 2'd0;
            left_d     = left_dec;
            have       = 1'b1;
            res.kind   = KIND_SAMPLE;
            res.sample = {s_axis_tdata, low_q};
            res.last   = (left_dec == '0);
          end
        end
        PH_DONE: begin
        end
        default: begin
          field_d    = fld_val;
          byte_cnt_d = byte_cnt_q + 2'd1;
          if (fld_done) begin
            field_d    = '0;
            byte_cnt_d = '0;
            // A failed check is visible as the phase dropping to PH_DONE.
            have = (phase_adv == PH_DONE);
            unique case (phase_q)
              PH_RIFF:  res.code = ERR_NOT_RIFF;
              PH_SIZE:  res.code = ERR_SIZE;
              PH_WAVE:  res.code = ERR_NOT_WAVE;
              PH_TAG:   res.code = ERR_NO_FMT;
              PH_FMT2:  res.code = ERR_NO_FMT2;
              PH_TYPE:  res.code = ERR_NOT_PCM;
              PH_TA:    res.code = ERR_NO_TA;
              default:  res.code = ERR_NOT_RIFF;
            endcase
            if (phase_q == PH_JLEN) begin
              skip_d = fld_val;
            end
            if (phase_q == PH_RATE) begin
              rate_d = fld_val;
            end
            if (phase_q == PH_DSIZE) begin
              left_d    = cnt_new;
              have      = 1'b1;
              res       = '0;
              res.kind  = KIND_HEADER;
              res.rate  = rate_q;
              res.count = cnt_new;
            end
          end
        end
      endcase

      if (s_axis_tlast) begin
        // End of file while more bytes were due overrides any other word.
        if (phase_adv != PH_DONE) begin
          have     = 1'b1;
          res      = '0;
          res.kind = KIND_ERROR;
          res.code = ERR_TRUNCATED;
        end
        byte_cnt_d = '0;
        field_d    = '0;
        skip_d     = '0;
        pos_d      = '0;
        rate_d     = '0;
        left_d     = '0;
        low_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_RIFF;
      byte_cnt_q <= '0;
      field_q    <= '0;
      skip_q     <= '0;
      pos_q      <= '0;
      rate_q     <= '0;
      left_q     <= '0;
      low_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      field_q    <= field_d;
      skip_q     <= skip_d;
      pos_q      <= pos_d;
      rate_q     <= rate_d;
      left_q     <= left_d;
      low_q      <= low_d;
    end
  end

  wavp_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (accept && have),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A held result word must stall the byte input so it is never overwritten.
  a_hold_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while a result word is stalled");

  // End of file always returns the parser to the start of a new header.
  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (phase_q == PH_RIFF && pos_q == '0 && left_q == '0))
    else $error("parser did not restart after end of file");

  // Once done, ordinary bytes produce no result word.
  a_done_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_DONE && !s_axis_tlast) |-> !have)
    else $error("result produced in the done phase");

  // A marked last sample is a sample word.
  a_last_is_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_SAMPLE))
    else $error("last flag on a word that is not a sample");

endmodule

// File: tb/wavp_stream_checker.sv
// Scoreboard for the WAV 16-bit PCM parser: watches the file-size, byte and result channels.
// It predicts each result word from the accepted bytes and compares it on arrival.
// Depends on wavp_pkg for the phase, kind and error code enums and the tag constants.
`timescale 1ns / 1ps

module wavp_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // s_tdata_i: data_byte[7:0]
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // m_tdata_i: sample[15:0], rate[47:16], sample_count[78:48],
  // error_code[81:79], zero fill[87:82]
  input  logic [87:0] m_tdata_i,
  // m_tuser_i: kind[1:0]
  input  logic [1:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          words_due_o
);

  import wavp_pkg::*;

  typedef struct packed {
    wavp_kind_e  kind;
    logic [15:0] sample;
    logic [31:0] rate;
    logic [30:0] count;
    wavp_err_e   code;
    logic        last;
  } parse_word_t;

  parse_word_t parsed_words_q[$];
  int          fails;

  logic [31:0] file_size_q;
  wavp_phase_e phase_q;
  logic [31:0] field_cnt_q;
  logic [31:0] field_acc_q;
  logic [31:0] consumed_q;
  logic [31:0] rate_q;
  logic [30:0] samples_left_q;
  logic [7:0]  low_byte_q;
  logic        failed_q;

  function automatic logic [31:0] field_bytes(input wavp_phase_e ph);
    case (ph)
      PH_SKIP, PH_DONE: return 32'd1;
      PH_TYPE, PH_CHAN, PH_ALIGN, PH_BITS, PH_SCAN, PH_TA, PH_SAMPLE: return 32'd2;
      default: return 32'd4;
    endcase
  endfunction

  task automatic restart_parse();
    phase_q        = PH_RIFF;
    field_cnt_q    = '0;
    field_acc_q    = '0;
    consumed_q     = '0;
    rate_q         = '0;
    samples_left_q = '0;
    low_byte_q     = '0;
    failed_q       = 1'b0;
  endtask

  // Advances the parse state by one file byte and queues the word it causes, if any.
  task automatic parse_byte(input logic [7:0] b, input logic eof);
    parse_word_t w;
    logic        emit;
    logic [31:0] v;
    logic [31:0] c;
    wavp_phase_e ph;
    w    = '0;
    emit = 1'b0;
    if (consumed_q != 32'hFFFF_FFFF) consumed_q++;
    // Once failed or finished, bytes are dropped until the end of the file.
    if (failed_q || phase_q == PH_DONE) begin
      if (eof) restart_parse();
      return;
    end
    if (phase_q == PH_SKIP) begin
      field_cnt_q--;
      if (field_cnt_q == 0) begin
        field_acc_q = '0;
        phase_q     = PH_FMT2;
      end
    end else if (phase_q == PH_SAMPLE) begin
      if (field_cnt_q == 0) begin
        low_byte_q  = b;
        field_cnt_q = 1;
      end else begin
        field_cnt_q    = 0;
        w.kind         = KIND_SAMPLE;
        w.sample       = {b, low_byte_q};
        emit           = 1'b1;
        samples_left_q = samples_left_q - 31'd1;
        if (samples_left_q == 0) begin
          w.last  = 1'b1;
          phase_q = PH_DONE;
        end
      end
    end else begin
      field_acc_q |= 32'(b) << (8 * field_cnt_q[1:0]);
      field_cnt_q++;
      if (field_cnt_q >= field_bytes(phase_q)) begin
        v           = field_acc_q;
        ph          = phase_q;
        field_acc_q = '0;
        field_cnt_q = '0;
        phase_q     = wavp_phase_e'(ph + 5'd1);
        case (ph)
          PH_RIFF: begin
            if (v != TAG_RIFF) begin
              failed_q = 1'b1;
              w.code   = ERR_NOT_RIFF;
            end
          end
          PH_SIZE: begin
            if (file_size_q < 32'd8 || v != file_size_q - 32'd8) begin
              failed_q = 1'b1;
              w.code   = ERR_SIZE;
            end
          end
          PH_WAVE: begin
            if (v != TAG_WAVE) begin
              failed_q = 1'b1;
              w.code   = ERR_NOT_WAVE;
            end
          end
          PH_TAG: begin
            if (v == TAG_JUNK) begin
              phase_q = PH_JLEN;
            end else if (v == TAG_FMT) begin
              phase_q = PH_CKSZ;
            end else begin
              failed_q = 1'b1;
              w.code   = ERR_NO_FMT;
            end
          end
          PH_JLEN: begin
            if (v == 0) begin
              phase_q = PH_FMT2;
            end else begin
              field_cnt_q = v;
              phase_q     = PH_SKIP;
            end
          end
          PH_FMT2: begin
            if (v != TAG_FMT) begin
              failed_q = 1'b1;
              w.code   = ERR_NO_FMT2;
            end
          end
          PH_TYPE: begin
            if (v != FMT_PCM) begin
              failed_q = 1'b1;
              w.code   = ERR_NOT_PCM;
            end
          end
          PH_RATE: rate_q = v;
          PH_SCAN: begin
            if (v != TAG_DA) phase_q = PH_SCAN;
          end
          PH_TA: begin
            if (v != TAG_TA) begin
              failed_q = 1'b1;
              w.code   = ERR_NO_TA;
            end
          end
          PH_DSIZE: begin
            // A zero data size falls back to what is left of the configured file.
            c = v >> 1;
            if (c == 0) c = (file_size_q > consumed_q) ? (file_size_q - consumed_q) >> 1 : '0;
            samples_left_q = c[30:0];
            w.kind         = KIND_HEADER;
            w.rate         = rate_q;
            w.count        = samples_left_q;
            emit           = 1'b1;
            phase_q        = (samples_left_q == 0) ? PH_DONE : PH_SAMPLE;
          end
          default: ;
        endcase
        if (failed_q) begin
          emit   = 1'b1;
          w.kind = KIND_ERROR;
        end
      end
    end
    // An end of file while bytes are still needed overrides a header or a
    // non-final sample, but not an error raised by this very byte.
    if (eof) begin
      if (!failed_q && phase_q != PH_DONE) begin
        w      = '0;
        w.kind = KIND_ERROR;
        w.code = ERR_TRUNCATED;
        emit   = 1'b1;
      end
      restart_parse();
    end
    if (emit) parsed_words_q.push_back(w);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fails++;
    end
  endtask

  task automatic check_word();
    parse_word_t w;
    if (parsed_words_q.size() == 0) begin
      $display("%0t: unexpected result word, expected none, actual tuser %h tdata %h",
               $time, m_tuser_i, m_tdata_i);
      fails++;
      return;
    end
    w = parsed_words_q.pop_front();
    check_field("kind", w.kind, m_tuser_i);
    check_field("sample", w.sample, m_tdata_i[15:0]);
    check_field("rate", w.rate, m_tdata_i[47:16]);
    check_field("sample_count", w.count, m_tdata_i[78:48]);
    check_field("error_code", w.code, m_tdata_i[81:79]);
    check_field("zero fill", '0, m_tdata_i[87:82]);
    check_field("last_sample", w.last, m_tlast_i);
  endtask

  // A result word can never stem from a byte taken at the same edge, so the
  // check runs before the byte is folded in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q = '0;
      restart_parse();
      parsed_words_q.delete();
      fails = 0;
      fail_count_o <= 0;
      words_due_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_word();
      if (cfg_valid_i && cfg_ready_i) file_size_q = cfg_data_i;
      if (s_tvalid_i && s_tready_i) parse_byte(s_tdata_i, s_tlast_i);
      fail_count_o <= fails;
      words_due_o  <= parsed_words_q.size();
    end
  end

endmodule

// File: tb/wav_header_pcm16_parser_test.sv
// Top of the WAV 16-bit PCM parser testbench: clock, reset, byte stimulus and verdict.
// Instantiates wav_header_pcm16_parser and wavp_stream_checker; uses wavp_pkg tag constants.
`timescale 1ns / 1ps

module wav_header_pcm16_parser_test;

  import wavp_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // tdata: data_byte[7:0]
  logic [7:0]  s_axis_tdata;
  // tlast: end_of_file
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tdata: sample[15:0], rate[47:16], sample_count[78:48],
  // error_code[81:79], zero fill[87:82]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // tuser: kind[1:0]
  logic [1:0]  m_axis_tuser;
  // tlast: last_sample
  logic        m_axis_tlast;

  int fail_count;
  int words_due;

  // Percentage of cycles in which the byte source holds back and the result
  // sink refuses a word. Both change at set points between test phases.
  int src_idle_pct;
  int snk_idle_pct;

  // The bytes of the next file to send, and the file size last programmed.
  logic [7:0]  wav_bytes_q[$];
  logic [31:0] file_size_cur;
  int          bytes_sent;

  // File sizes for the random phases. The sizes 0 and 5 make every RIFF size
  // check fail; 52 and 60 leave a handful of samples for a zero data size,
  // or none at all once a JUNK chunk has eaten the rest. The last entry is
  // replaced by a random size.
  logic [31:0] size_plan [8] = '{32'd0, 32'd5, 32'd8, 32'd52, 32'd60, 32'd1000,
                                 32'hFFFF_FFFF, 32'd0};
  int          byte_plan [8] = '{50, 50, 50, 200, 200, 200, 170, 200};

  wav_header_pcm16_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  wavp_stream_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The result sink decides afresh at every edge whether it takes a word.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Byte values lean on the extremes now and then, so that samples reach
  // full scale in both directions.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Fields of a WAV file are little-endian, lowest byte first.
  task automatic put16(input logic [15:0] v);
    wav_bytes_q.push_back(v[7:0]);
    wav_bytes_q.push_back(v[15:8]);
  endtask

  task automatic put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  // Offers one byte word and holds it until the parser takes it. The source
  // may idle first, which drops tvalid while it waits.
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sends the queued file, marking its final byte as the end of file.
  task automatic send_file();
    foreach (wav_bytes_q[i]) push_byte(wav_bytes_q[i], i == wav_bytes_q.size() - 1);
    bytes_sent += wav_bytes_q.size();
  endtask

  // Waits until every predicted word has been taken. The wait before the check
  // covers the last byte still being folded into the prediction; the tail after
  // it covers the output register for bytes that cause no word.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // The parser is idle whenever this is called, so the new size cannot land
  // in the middle of a file.
  task automatic write_file_size(input logic [31:0] v);
    cfg_valid_i   <= 1'b1;
    cfg_data_i    <= v;
    file_size_cur  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Builds a mostly well-formed file with random content: an optional JUNK
  // chunk, a full fmt chunk, a few filler words before the data tag, and a
  // data size that is exact, odd, zero (count from the file size) or huge.
  // The sample bytes then match the count, overrun it, or stop short.
  task automatic build_wav_file();
    logic [31:0] junk_len;
    logic [31:0] data_size;
    logic [31:0] n_samples;
    int          nb;
    int          r;
    wav_bytes_q.delete();
    put32(TAG_RIFF);
    put32($urandom_range(9) ? file_size_cur - 32'd8 : rand_word());
    put32(TAG_WAVE);
    if ($urandom_range(99) < 30) begin
      put32(TAG_JUNK);
      case ($urandom_range(19))
        0, 1, 2, 3, 4: junk_len = 32'd0;
        // A huge skip swallows everything up to the end of file.
        19:            junk_len = $urandom();
        default:       junk_len = $urandom_range(1, 5);
      endcase
      put32(junk_len);
      repeat ((junk_len > 8) ? 8 : junk_len) wav_bytes_q.push_back(rand_byte());
    end
    put32(TAG_FMT);
    put32(rand_word());
    put16($urandom_range(19) ? FMT_PCM[15:0] : 16'($urandom()));
    put16(16'($urandom()));
    put32(rand_word());
    put32(rand_word());
    put16(16'($urandom()));
    put16(16'($urandom()));
    repeat ($urandom_range(0, 3)) put16(16'($urandom()));
    put16(TAG_DA[15:0]);
    put16($urandom_range(19) ? TAG_TA[15:0] : 16'($urandom()));
    r = $urandom_range(99);
    if (r < 25)      data_size = 32'd0;
    else if (r < 85) data_size = 2 * $urandom_range(0, 10) + $urandom_range(0, 1);
    else             data_size = rand_word();
    put32(data_size);
    // The count the parser should announce, used only to size the data part.
    n_samples = data_size >> 1;
    if (n_samples == 0) begin
      n_samples = (file_size_cur > wav_bytes_q.size()) ?
                  (file_size_cur - wav_bytes_q.size()) >> 1 : 32'd0;
    end
    n_samples &= 32'h7FFF_FFFF;
    if (n_samples <= 12) begin
      nb = 2 * n_samples;
      r  = $urandom_range(99);
      if (r < 30)                nb += $urandom_range(1, 3);
      else if (r < 45 && nb > 0) nb -= $urandom_range(1, nb);
    end else begin
      nb = $urandom_range(0, 20);
    end
    repeat (nb) wav_bytes_q.push_back(rand_byte());
  endtask

  // Picks the next file: mostly well-formed, some plain noise, and some
  // well-formed files with a damaged byte and perhaps a premature end.
  task automatic queue_next_file();
    int r;
    int keep;
    r = $urandom_range(99);
    if (r < 80) begin
      build_wav_file();
    end else if (r < 90) begin
      wav_bytes_q.delete();
      repeat ($urandom_range(1, 12)) wav_bytes_q.push_back(rand_byte());
    end else begin
      build_wav_file();
      wav_bytes_q[$urandom_range(0, wav_bytes_q.size() - 1)] = rand_byte();
      if ($urandom_range(1)) begin
        keep = $urandom_range(1, wav_bytes_q.size());
        while (wav_bytes_q.size() > keep) void'(wav_bytes_q.pop_back());
      end
    end
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    src_idle_pct  = 37;
    snk_idle_pct  = 45;
    bytes_sent    = 0;
    file_size_cur = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed files with a zero file size. A bad RIFF tag, with the byte
    // after the error ignored until the end of file.
    write_file_size(32'd0);
    wav_bytes_q = {8'h52, 8'h49, 8'h46, 8'h58, 8'hFF};
    send_file();
    // A correct tag, but a file too small for its RIFF size ever to match.
    wav_bytes_q.delete();
    put32(TAG_RIFF);
    put32(32'd0);
    wav_bytes_q.push_back(8'h00);
    send_file();
    // A file that ends after its first byte.
    wav_bytes_q = {8'h52};
    send_file();

    // Random phases, each under its own file size. The source and sink idle
    // as planned: source at 37 and sink at 45 percent first, then the other
    // way round, then neither idles at all.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        src_idle_pct = 45;
        snk_idle_pct = 37;
      end
      if (ph == 6) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      drain();
      write_file_size((ph == 7) ? 32'($urandom_range(40, 400)) : size_plan[ph]);
      bytes_sent = 0;
      while (bytes_sent < byte_plan[ph]) begin
        queue_next_file();
        send_file();
      end
    end
    drain();

    if (fail_count == 0 && words_due == 0) begin
      $display("wav_header_pcm16_parser_test OK");
    end else begin
      $display("wav_header_pcm16_parser_test NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about 1400 bytes.
  initial begin
    #5_000_000;
    $display("wav_header_pcm16_parser_test NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/core/wavp_pkg.sv
rtl/core/wavp_out_reg.sv
rtl/core/wav_header_pcm16_parser.sv
tb/wavp_stream_checker.sv
tb/wav_header_pcm16_parser_test.sv
